// ----- hdl/wcdt_pkg.sv -----
// Package for the weighted case draw table: request and response structs,
// opcodes, table sizing and fixed-point constants. No dependencies.
package wcdt_pkg;

  localparam int MAX_CASES = 16;
  localparam int ADDR_W    = $clog2(MAX_CASES);
  localparam int CNT_W     = $clog2(MAX_CASES + 1);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_DRAW   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [22:0] ADD_LIMIT = 23'd6560153;
  localparam logic [22:0] HUNDRED   = 23'd6553600;
  localparam logic [30:0] LCG_SEED  = 31'd42;
  localparam logic [15:0] LCG_MUL   = 16'd48271;
  localparam logic [31:0] LCG_MOD   = 32'd2147483647;
  localparam logic [31:0] ROLL_DIV  = 32'd2147483646;
  localparam logic [8:0]  SCALE_MAX = 9'd256;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] case_id;
    logic [22:0] weight;
    logic [15:0] ratio;
    logic [8:0]  scale;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        drew_case;
    logic [15:0] chosen_id;
    logic [22:0] weight_out;
    logic [22:0] total_out;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [22:0] weight;
  } entry_t;

endpackage

// ----- hdl/weighted_case_draw_table.sv -----
// Weighted case draw table: sorted case memory with add, remove, scale,
// draw and read. Depends on wcdt_pkg.
//
//  channel   signals                 direction  handshake
//  request   start, busy, req        in         start & !busy
//  response  done, rsp               out        done, one cycle, no stall
//  config    cfg_we, cfg_data        in         cfg_we
//
// Add, remove, multiply and read scan the table entry by entry up to the
// id, then execute; insert and remove then shift each entry that moves,
// and multiply adds a cap step.
// A draw runs the LCG step, roll division and scale reduction, a normalize
// multiply when normalizing, then walks entries until a hit or the end.
// FINISH registers the response and done together.
// The entry memory takes one read and one write a cycle; reads are registered.
// Reset clears count, total and normalize mode and reloads the LCG seed;
// entries are not cleared. Results cannot be stalled.
module weighted_case_draw_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  wcdt_pkg::req_t  req,
  input  logic            cfg_we,
  input  logic            cfg_data,
  output logic            done,
  output wcdt_pkg::rsp_t  rsp
);
  import wcdt_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE     = 17'b00000000000000001,
    S_SCAN_RD  = 17'b00000000000000010,
    S_SCAN_CK  = 17'b00000000000000100,
    S_EXEC     = 17'b00000000000001000,
    S_SH_RD    = 17'b00000000000010000,
    S_SH_WR    = 17'b00000000000100000,
    S_MUL_CAP  = 17'b00000000001000000,
    S_LCG_MUL  = 17'b00000000010000000,
    S_LCG_RED  = 17'b00000000100000000,
    S_ROLL_MUL = 17'b00000001000000000,
    S_DIV      = 17'b00000010000000000,
    S_RED_MUL  = 17'b00000100000000000,
    S_RED_SUB  = 17'b00001000000000000,
    S_NRM_MUL  = 17'b00010000000000000,
    S_WALK_RD  = 17'b00100000000000000,
    S_WALK_CK  = 17'b01000000000000000,
    S_FINISH   = 17'b10000000000000000
  } state_t;

  state_t state, state_next;

  entry_t mem [MAX_CASES];
  entry_t rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  entry_t            mem_wd;

  req_t        req_q, req_q_next;
  logic [CNT_W-1:0] idx, idx_next, pos, pos_next, count, count_next;
  logic        found, found_next;
  entry_t      cur, cur_next;
  logic [22:0] total, total_next;
  logic [30:0] lcg, lcg_next;
  logic        norm;
  logic [47:0] prod, prod_next;
  logic [52:0] dnum, dnum_next;
  logic [22:0] quo, quo_next;
  logic [22:0] roll, roll_next;
  logic [45:0] rs, rs_next;
  logic [22:0] acc, acc_next;
  logic        status_q, status_q_next, drew_q, drew_q_next;
  logic [15:0] chosen_q, chosen_q_next;
  logic [22:0] wout_q, wout_q_next;

  logic [31:0] lcg_sum;
  logic [30:0] dsum;
  logic [22:0] others, remv, accn, neww;
  logic [30:0] pv;
  logic [8:0]  sc;
  logic        hit;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_next    = state;
    req_q_next    = req_q;
    idx_next      = idx;
    pos_next      = pos;
    count_next    = count;
    found_next    = found;
    cur_next      = cur;
    total_next    = total;
    lcg_next      = lcg;
    prod_next     = prod;
    dnum_next     = dnum;
    quo_next      = quo;
    roll_next     = roll;
    rs_next       = rs;
    acc_next      = acc;
    status_q_next = status_q;
    drew_q_next   = drew_q;
    chosen_q_next = chosen_q;
    wout_q_next   = wout_q;
    rd_addr       = idx[ADDR_W-1:0];
    mem_we        = 1'b0;
    mem_wa        = pos[ADDR_W-1:0];
    mem_wd        = cur;

    lcg_sum = {1'b0, prod[30:0]} + 32'(prod[46:31]);
    dsum    = 31'(dnum[52:30]) + 31'(dnum[29:0]);
    others  = total - cur.weight;
    remv    = (others < HUNDRED) ? (HUNDRED - others) : 23'd0;
    pv      = prod[38:8];
    neww    = (pv < 31'(remv)) ? pv[22:0] : remv;
    sc      = (req_q.scale > SCALE_MAX) ? SCALE_MAX : req_q.scale;
    accn    = acc + rd_q.weight;
    hit     = norm ? (rs <= 46'(accn) * 46'(HUNDRED)) : (roll <= accn);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_q_next    = req;
          status_q_next = 1'b1;
          drew_q_next   = 1'b0;
          chosen_q_next = '0;
          wout_q_next   = '0;
          idx_next      = '0;
          state_next    = S_SCAN_RD;
          if (req.opcode > OP_READ) begin
            state_next = S_FINISH;
          end else if (req.opcode == OP_DRAW) begin
            status_q_next = 1'b0;
            state_next    = (count == '0) ? S_FINISH : S_LCG_MUL;
          end else if (req.opcode == OP_ADD &&
                       (24'(total) + 24'(req.weight) > 24'(ADD_LIMIT))) begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx == count) begin
          pos_next   = idx;
          found_next = 1'b0;
          state_next = S_EXEC;
        end else begin
          state_next = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (rd_q.id >= req_q.case_id) begin
          pos_next   = idx;
          found_next = (rd_q.id == req_q.case_id);
          cur_next   = rd_q;
          state_next = S_EXEC;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        case (req_q.opcode)
          OP_ADD: begin
            if (found) begin
              mem_we        = 1'b1;
              mem_wd        = '{id: cur.id, weight: cur.weight + req_q.weight};
              total_next    = total + req_q.weight;
              status_q_next = 1'b0;
            end else if (count != CNT_W'(MAX_CASES)) begin
              idx_next   = count;
              state_next = S_SH_RD;
            end
          end
          OP_REMOVE: begin
            if (found) begin
              total_next    = total - cur.weight;
              status_q_next = 1'b0;
              idx_next      = pos;
              state_next    = S_SH_RD;
            end
          end
          OP_MUL: begin
            if (found) begin
              prod_next  = 48'(cur.weight) * 48'(req_q.ratio);
              state_next = S_MUL_CAP;
            end
          end
          default: begin
            if (found) begin
              wout_q_next   = cur.weight;
              status_q_next = 1'b0;
            end
          end
        endcase
      end
      S_SH_RD: begin
        if (req_q.opcode == OP_ADD) begin
          if (idx > pos) begin
            rd_addr    = ADDR_W'(idx - CNT_W'(1));
            state_next = S_SH_WR;
          end else begin
            mem_we        = 1'b1;
            mem_wd        = '{id: req_q.case_id, weight: req_q.weight};
            count_next    = count + CNT_W'(1);
            total_next    = total + req_q.weight;
            status_q_next = 1'b0;
            state_next    = S_FINISH;
          end
        end else begin
          if ((idx + CNT_W'(1)) < count) begin
            rd_addr    = ADDR_W'(idx + CNT_W'(1));
            state_next = S_SH_WR;
          end else begin
            count_next = count - CNT_W'(1);
            state_next = S_FINISH;
          end
        end
      end
      S_SH_WR: begin
        mem_we     = 1'b1;
        mem_wa     = idx[ADDR_W-1:0];
        mem_wd     = rd_q;
        idx_next   = (req_q.opcode == OP_ADD) ? idx - CNT_W'(1) : idx + CNT_W'(1);
        state_next = S_SH_RD;
      end
      S_MUL_CAP: begin
        mem_we        = 1'b1;
        mem_wd        = '{id: cur.id, weight: neww};
        total_next    = others + neww;
        status_q_next = 1'b0;
        state_next    = S_FINISH;
      end
      S_LCG_MUL: begin
        prod_next  = 48'(lcg) * 48'(LCG_MUL);
        state_next = S_LCG_RED;
      end
      S_LCG_RED: begin
        lcg_next   = (lcg_sum >= LCG_MOD) ? 31'(lcg_sum - LCG_MOD) : lcg_sum[30:0];
        state_next = S_ROLL_MUL;
      end
      S_ROLL_MUL: begin
        dnum_next  = 53'(lcg - 31'd1) * 53'(HUNDRED >> 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        quo_next   = dnum[52:30] + ((dsum >= 31'(ROLL_DIV >> 1)) ? 23'd1 : 23'd0);
        state_next = S_RED_MUL;
      end
      S_RED_MUL: begin
        prod_next  = 48'(quo) * 48'(sc);
        state_next = S_RED_SUB;
      end
      S_RED_SUB: begin
        roll_next = quo - prod[30:8];
        idx_next  = '0;
        acc_next  = '0;
        if (norm && total == '0) begin
          state_next = S_FINISH;
        end else begin
          state_next = norm ? S_NRM_MUL : S_WALK_RD;
        end
      end
      S_NRM_MUL: begin
        rs_next    = 46'(roll) * 46'(total);
        state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_next = (idx == count) ? S_FINISH : S_WALK_CK;
      end
      S_WALK_CK: begin
        if (hit) begin
          drew_q_next   = 1'b1;
          chosen_q_next = rd_q.id;
          state_next    = S_FINISH;
        end else begin
          acc_next   = accn;
          idx_next   = idx + CNT_W'(1);
          state_next = S_WALK_RD;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      lcg   <= LCG_SEED;
      norm  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      total <= total_next;
      lcg   <= lcg_next;
      if (cfg_we) begin
        norm <= cfg_data;
      end
      done <= (state == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    req_q    <= req_q_next;
    idx      <= idx_next;
    pos      <= pos_next;
    found    <= found_next;
    cur      <= cur_next;
    prod     <= prod_next;
    dnum     <= dnum_next;
    quo      <= quo_next;
    roll     <= roll_next;
    rs       <= rs_next;
    acc      <= acc_next;
    status_q <= status_q_next;
    drew_q   <= drew_q_next;
    chosen_q <= chosen_q_next;
    wout_q   <= wout_q_next;
    if (state == S_FINISH) begin
      rsp <= '{status: status_q, drew_case: drew_q, chosen_id: chosen_q,
               weight_out: wout_q, total_out: total};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CASES)) else $error("entry count above table size");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted without going busy");

  a_lcg_nonzero: assert property (@(posedge clk) disable iff (rst)
    lcg != '0) else $error("LCG state collapsed to zero");

  a_total_limit: assert property (@(posedge clk) disable iff (rst)
    total <= ADD_LIMIT) else $error("weight total above add limit");

endmodule
